// ----- hw/rtl/mqfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqfe_pkg
// Shared codes and the beat type that walks the queue cell chain.
// ----------------------------------------------------------------------------
package mqfe_pkg;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int QID_W    = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_LIST = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_LISTED   = 3'd4
    } status_t;

    // Command beat handed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic [CMD_W-1:0]          cmd;
        logic [QID_W-1:0]          qid;
        logic                      ok;
        logic signed [VALUE_W-1:0] value;
    } beat_t;

endpackage

// ----- hw/rtl/mqfe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqfe interfaces
// Valid/ready channels for commands, results and the capacity register.
// ----------------------------------------------------------------------------
interface mqfe_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [mqfe_pkg::CMD_W-1:0]            cmd;
    logic [mqfe_pkg::QID_W-1:0]            queue_id;
    logic signed [mqfe_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output cmd, output queue_id, output value, input ready);
    modport sink   (input valid, input cmd, input queue_id, input value, output ready);
endinterface

interface mqfe_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [mqfe_pkg::STATUS_W-1:0]         status;
    logic signed [mqfe_pkg::VALUE_W-1:0]   data;
    logic                                  last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

interface mqfe_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mqfe_pkg::CFG_W-1:0]            queue_capacity;

    modport source (output valid, output queue_capacity, input ready);
    modport sink   (input valid, input queue_capacity, output ready);
endinterface

// ----- hw/rtl/mqfe_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data when no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/mqfe_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqfe_cell
// One queue's head and count; claims the passing beat if it names this queue.
// ----------------------------------------------------------------------------
module mqfe_cell #(
    parameter int CAPACITY_MAX = 16,
    parameter int IDX          = 0
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic [((CAPACITY_MAX + 1 > 32 ? $clog2(CAPACITY_MAX + 1) : 5))-1:0] cap,
    input  mqfe_pkg::beat_t                                          beat_in,
    input  logic [(CAPACITY_MAX > 1 ? $clog2(CAPACITY_MAX) : 1)-1:0] head_in,
    input  logic [$clog2(CAPACITY_MAX + 1)-1:0]                      cnt_in,
    output mqfe_pkg::beat_t                                          beat_out,
    output logic [(CAPACITY_MAX > 1 ? $clog2(CAPACITY_MAX) : 1)-1:0] head_out,
    output logic [$clog2(CAPACITY_MAX + 1)-1:0]                      cnt_out
);

    localparam int HEAD_W = CAPACITY_MAX > 1 ? $clog2(CAPACITY_MAX) : 1;
    localparam int CNT_W  = $clog2(CAPACITY_MAX + 1);
    localparam int CMP_W  = CAPACITY_MAX + 1 > 32 ? $clog2(CAPACITY_MAX + 1) : 5;

    logic [HEAD_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    mqfe_pkg::beat_t   beat_reg, beat_next;
    logic [HEAD_W-1:0] head_out_reg, head_out_next;
    logic [CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    always_comb
    begin
        beat_next     = beat_in;
        head_out_next = head_in;
        cnt_out_next  = cnt_in;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        if (beat_in.valid && (32'(beat_in.qid) == IDX))
        begin
            // hand on this queue's state as it was before the command
            head_out_next = head_reg;
            cnt_out_next  = cnt_reg;
            unique case (beat_in.cmd)
                mqfe_pkg::CMD_PUSH:
                begin
                    beat_next.ok = CMP_W'(cnt_reg) < cap;
                    if (CMP_W'(cnt_reg) < cap)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                mqfe_pkg::CMD_POP:
                begin
                    beat_next.ok = cnt_reg != '0;
                    if (cnt_reg != '0)
                    begin
                        cnt_next  = cnt_reg - CNT_W'(1);
                        head_next = (head_reg == HEAD_W'(CAPACITY_MAX - 1)) ?
                                    '0 : head_reg + HEAD_W'(1);
                    end
                end
                mqfe_pkg::CMD_LIST:
                begin
                    beat_next.ok = cnt_reg != '0;
                end
                default:
                begin
                    beat_next.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
            beat_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_out_reg <= head_out_next;
        cnt_out_reg  <= cnt_out_next;
    end

    assign beat_out = beat_reg;
    assign head_out = head_out_reg;
    assign cnt_out  = cnt_out_reg;

endmodule

// ----- hw/rtl/multi_queue_fifo_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_fifo_engine_top
// Several bounded FIFO queues sharing one entry RAM and one command port.
// ----------------------------------------------------------------------------
// Each command walks a chain of NUM_QUEUES cells, one cell per cycle; the cell
// of the addressed queue checks and updates its head and count on the way.
// The engine then writes or reads the shared entry RAM and returns results.
// One command is in flight at a time, and a display of n entries streams
// one entry per cycle from the RAM's single read port while the result
// side keeps up. The capacity register is written only while the engine
// is idle, ahead of a waiting command, and resets to 16; values above
// CAPACITY_MAX act as CAPACITY_MAX.
module multi_queue_fifo_engine_top #(
    parameter int NUM_QUEUES   = 4,
    parameter int CAPACITY_MAX = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mqfe_req_if.sink    req,
    mqfe_rsp_if.source  rsp,
    mqfe_cfg_if.sink    cfg
);

    localparam int HEAD_W = CAPACITY_MAX > 1 ? $clog2(CAPACITY_MAX) : 1;
    localparam int CNT_W  = $clog2(CAPACITY_MAX + 1);
    localparam int CMP_W  = CAPACITY_MAX + 1 > 32 ? $clog2(CAPACITY_MAX + 1) : 5;
    localparam int SUM_W  = CNT_W + 1;
    localparam int DEPTH  = NUM_QUEUES * CAPACITY_MAX;
    localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int VW     = mqfe_pkg::VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_EXEC = 4'b0100,
        S_LIST = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [mqfe_pkg::CFG_W-1:0] capacity_reg;
    logic [CMP_W-1:0]           cap_eff;

    mqfe_pkg::beat_t   chain_beat [NUM_QUEUES + 1];
    logic [HEAD_W-1:0] chain_head [NUM_QUEUES + 1];
    logic [CNT_W-1:0]  chain_cnt  [NUM_QUEUES + 1];

    logic [mqfe_pkg::CMD_W-1:0] job_cmd_reg;
    logic [mqfe_pkg::QID_W-1:0] job_q_reg;
    logic                       job_ok_reg;
    logic signed [VW-1:0]       job_value_reg;
    logic [HEAD_W-1:0]          job_head_reg;
    logic [CNT_W-1:0]           job_cnt_reg;

    logic [CNT_W-1:0] list_idx_reg, list_idx_next;
    logic [CNT_W-1:0] emit_idx_reg, emit_idx_next;
    logic             rd_pend_reg, rd_pend_next;

    logic                          out_valid_reg, out_valid_next;
    logic [mqfe_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic signed [VW-1:0]          out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    logic          out_free;
    logic          req_accept;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] rd_data;
    logic          list_load;

    function automatic logic [AW-1:0] slot_addr(
        input logic [mqfe_pkg::QID_W-1:0] q,
        input logic [HEAD_W-1:0]          head,
        input logic [CNT_W-1:0]           off
    );
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] wrapped;
        begin
            sum     = SUM_W'(head) + SUM_W'(off);
            wrapped = (sum >= SUM_W'(CAPACITY_MAX)) ? sum - SUM_W'(CAPACITY_MAX) : sum;
            slot_addr = AW'(32'(q) * CAPACITY_MAX + 32'(wrapped));
        end
    endfunction

    function automatic logic [mqfe_pkg::QID_W-1:0] qid_wrap(
        input logic [mqfe_pkg::QID_W-1:0] q
    );
        logic [mqfe_pkg::QID_W-1:0] r;
        begin
            r = q;
            // fold ids past the last queue back into range
            for (int k = 0; k < (1 << mqfe_pkg::QID_W); k++)
            begin
                if (32'(r) >= NUM_QUEUES)
                begin
                    r = r - mqfe_pkg::QID_W'(NUM_QUEUES);
                end
            end
            qid_wrap = r;
        end
    endfunction

    // ------------------------------------------------------------------ config
    assign cfg.ready = state_reg == S_IDLE;
    assign cap_eff   = (CMP_W'(capacity_reg) > CMP_W'(CAPACITY_MAX)) ?
                       CMP_W'(CAPACITY_MAX) : CMP_W'(capacity_reg);

    // ------------------------------------------------------------------ chain
    // hold commands while a capacity write is offered
    assign req.ready  = (state_reg == S_IDLE) && !cfg.valid;
    assign req_accept = req.valid && req.ready;

    always_comb
    begin
        chain_beat[0].valid = req_accept;
        chain_beat[0].cmd   = req.cmd;
        chain_beat[0].qid   = qid_wrap(req.queue_id);
        chain_beat[0].ok    = 1'b0;
        chain_beat[0].value = req.value;
    end
    assign chain_head[0] = '0;
    assign chain_cnt[0]  = '0;

    for (genvar i = 0; i < NUM_QUEUES; i++)
    begin : g_cell
        mqfe_cell #(
            .CAPACITY_MAX (CAPACITY_MAX),
            .IDX          (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cap      (cap_eff),
            .beat_in  (chain_beat[i]),
            .head_in  (chain_head[i]),
            .cnt_in   (chain_cnt[i]),
            .beat_out (chain_beat[i+1]),
            .head_out (chain_head[i+1]),
            .cnt_out  (chain_cnt[i+1])
        );
    end

    // ------------------------------------------------------------------ RAM
    assign wr_addr = slot_addr(job_q_reg, job_head_reg, job_cnt_reg);
    assign rd_addr = slot_addr(job_q_reg, job_head_reg, list_idx_reg);

    mqfe_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (job_value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------ control
    assign out_free  = !out_valid_reg || rsp.ready;
    assign list_load = (state_reg == S_LIST) && rd_pend_reg && out_free;

    always_comb
    begin
        state_next      = state_reg;
        list_idx_next   = list_idx_reg;
        emit_idx_next   = emit_idx_reg;
        rd_pend_next    = rd_pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (chain_beat[NUM_QUEUES].valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (job_cmd_reg)
                    mqfe_pkg::CMD_PUSH:
                    begin
                        if (out_free)
                        begin
                            wr_en           = job_ok_reg;
                            out_valid_next  = 1'b1;
                            out_status_next = job_ok_reg ? mqfe_pkg::ST_INSERTED :
                                                           mqfe_pkg::ST_FULL;
                            out_data_next   = '0;
                            out_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    mqfe_pkg::CMD_POP:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = job_ok_reg ? mqfe_pkg::ST_DELETED :
                                                           mqfe_pkg::ST_EMPTY;
                            out_data_next   = '0;
                            out_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    mqfe_pkg::CMD_LIST:
                    begin
                        if (job_ok_reg)
                        begin
                            list_idx_next = '0;
                            emit_idx_next = '0;
                            rd_pend_next  = 1'b0;
                            state_next    = S_LIST;
                        end
                        else if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = mqfe_pkg::ST_EMPTY;
                            out_data_next   = '0;
                            out_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // drop unknown command without a result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LIST:
            begin
                // issue the next read only if its data will have a place to go
                rd_en = (list_idx_reg != job_cnt_reg) && (!rd_pend_reg || list_load);
                if (rd_en)
                begin
                    list_idx_next = list_idx_reg + CNT_W'(1);
                end
                if (list_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = mqfe_pkg::ST_LISTED;
                    out_data_next   = rd_data;
                    out_last_next   = (emit_idx_reg + CNT_W'(1)) == job_cnt_reg;
                    emit_idx_next   = emit_idx_reg + CNT_W'(1);
                    if ((emit_idx_reg + CNT_W'(1)) == job_cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                rd_pend_next = rd_en || (rd_pend_reg && !list_load);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= mqfe_pkg::CFG_W'(16);
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.queue_capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WALK) && chain_beat[NUM_QUEUES].valid)
        begin
            job_cmd_reg   <= chain_beat[NUM_QUEUES].cmd;
            job_q_reg     <= chain_beat[NUM_QUEUES].qid;
            job_ok_reg    <= chain_beat[NUM_QUEUES].ok;
            job_value_reg <= chain_beat[NUM_QUEUES].value;
            job_head_reg  <= chain_head[NUM_QUEUES];
            job_cnt_reg   <= chain_cnt[NUM_QUEUES];
        end
        list_idx_reg   <= list_idx_next;
        emit_idx_reg   <= emit_idx_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

endmodule
